[src/rfkm_pkg.sv]
// Package: request/response payload types, event codes and frame constants.
package rfkm_pkg;

   // Request kinds
   typedef enum logic [1:0] {
      MODE_KEY    = 2'd0,
      MODE_MOTION = 2'd1,
      MODE_TICK   = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   // Register indexes
   localparam logic [1:0] CSR_MOUSE_GAIN   = 2'd0;
   localparam logic [1:0] CSR_INVERT_VERT  = 2'd1;
   localparam logic [1:0] CSR_LEFT_SWITCH  = 2'd2;
   localparam logic [1:0] CSR_RIGHT_SWITCH = 2'd3;

   localparam int CSR_DATA_W = 16;

   // Event codes
   localparam logic [9:0] CODE_REL_X   = 10'd0;
   localparam logic [9:0] CODE_REL_Y   = 10'd1;
   localparam logic [9:0] CODE_MOUSE_L = 10'd272;
   localparam logic [9:0] CODE_MOUSE_R = 10'd273;

   localparam int FRAME_LEN  = 18;
   localparam int IDX_W      = 5;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

   // Frame byte positions
   localparam logic [IDX_W-1:0] B_SWITCH  = 5'd5;
   localparam logic [IDX_W-1:0] B_MX_LO   = 5'd6;
   localparam logic [IDX_W-1:0] B_MX_HI   = 5'd7;
   localparam logic [IDX_W-1:0] B_MY_LO   = 5'd8;
   localparam logic [IDX_W-1:0] B_MY_HI   = 5'd9;
   localparam logic [IDX_W-1:0] B_LBTN    = 5'd12;
   localparam logic [IDX_W-1:0] B_RBTN    = 5'd13;
   localparam logic [IDX_W-1:0] B_KEY_LO  = 5'd14;
   localparam logic [IDX_W-1:0] B_KEY_HI  = 5'd15;

   // Stick channels sit at centre
   localparam logic [10:0] CH_CENTER = 11'd1024;

   typedef struct packed {
      logic [1:0]         mode;
      logic [9:0]         event_code;
      logic signed [31:0] event_value;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] bit_idx;
   } key_hit_type;

   // evdev key code to key mask bit
   function automatic key_hit_type key_lookup(input logic [9:0] code);
      key_hit_type r;
      r = '{hit: 1'b1, bit_idx: 4'd0};
      unique case (code)
         10'd17:         r.bit_idx = 4'd0;
         10'd31:         r.bit_idx = 4'd1;
         10'd32:         r.bit_idx = 4'd2;
         10'd30:         r.bit_idx = 4'd3;
         10'd42, 10'd54: r.bit_idx = 4'd4;
         10'd29, 10'd97: r.bit_idx = 4'd5;
         10'd16:         r.bit_idx = 4'd6;
         10'd18:         r.bit_idx = 4'd7;
         10'd19:         r.bit_idx = 4'd8;
         10'd33:         r.bit_idx = 4'd9;
         10'd34:         r.bit_idx = 4'd10;
         10'd44:         r.bit_idx = 4'd11;
         10'd45:         r.bit_idx = 4'd12;
         10'd46:         r.bit_idx = 4'd13;
         10'd47:         r.bit_idx = 4'd14;
         10'd48:         r.bit_idx = 4'd15;
         default:        r.hit     = 1'b0;
      endcase
      return r;
   endfunction

endpackage

[src/remote_frame_from_key_mouse.sv]
// Top level: key/mouse event tracker and 18-byte remote frame streamer.
//
//  port group | dir | handshake            | payload
//  -----------+-----+----------------------+----------------------------------
//  req_       | in  | req_valid/req_stall  | mode, event_code, event_value
//  rsp_       | out | rsp_valid/rsp_stall  | frame_byte, last_byte
//  csr_       | in  | csr_wr_en            | csr_index, csr_wdata (16 bit)
//
//  Key and motion requests update state at the edge they are taken: one per cycle.
//  A tick registers sum*gain products and a snapshot of keys/buttons, clears the
//  sums, then the streamer sends 18 bytes, one per cycle of the output register
//  while rsp_stall is low. A tick is held off while the previous frame is still
//  streaming; key and motion requests keep flowing meanwhile.
//  Synchronous active-high reset; control, state and config registers get defaults.
//  rsp_stall holds output register and streamer; key and motion requests never wait.
module remote_frame_from_key_mouse #(
   parameter int SUM_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rfkm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rfkm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [1:0]                          csr_index,
   input  logic [rfkm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rfkm_pkg::*;

   // adder width: holds sum and a 32 bit delta plus carry
   localparam int AW = ((SUM_BITS > 32) ? SUM_BITS : 32) + 1;
   // product width, then scaled width with room for negation
   localparam int PW = SUM_BITS + 16;
   localparam int NW = PW - 7;

   localparam logic signed [AW-1:0] SUM_MAX =
      {{(AW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [AW-1:0] SUM_MIN = ~SUM_MAX;
   localparam logic signed [NW-1:0] MOUSE_MAX = NW'(32767);
   localparam logic signed [NW-1:0] MOUSE_MIN = -NW'(32768);

   // ---------------- configuration ----------------
   logic signed [15:0] gain_ff, gain_in;
   logic               inv_ff, inv_in;
   logic [1:0]         lsw_ff, lsw_in;
   logic [1:0]         rsw_ff, rsw_in;

   always_comb begin
      gain_in = gain_ff;
      inv_in  = inv_ff;
      lsw_in  = lsw_ff;
      rsw_in  = rsw_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MOUSE_GAIN:   gain_in = csr_wdata;
            CSR_INVERT_VERT:  inv_in  = csr_wdata[0];
            CSR_LEFT_SWITCH:  lsw_in  = csr_wdata[1:0];
            CSR_RIGHT_SWITCH: rsw_in  = csr_wdata[1:0];
            default:          ;
         endcase
      end
   end

   // ---------------- request side ----------------
   logic                       busy_ff, busy_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic                       out_load, send, send_last;
   logic                       req_take, is_tick;
   mode_type                   mode;

   assign mode      = mode_type'(req_data.mode);
   assign is_tick   = (mode == MODE_TICK);
   assign out_load  = !rsp_valid || !rsp_stall;
   assign send      = busy_ff && out_load;
   assign send_last = send && (idx_ff == LAST_IDX);
   // tick waits for the frame buffer; a tick may follow the last byte directly
   assign req_stall = is_tick && busy_ff && !send_last;
   assign req_take  = req_valid && !req_stall;

   // ---------------- key/button/motion state ----------------
   logic [15:0]                key_ff, key_in;
   logic                       lbtn_ff, lbtn_in, rbtn_ff, rbtn_in;
   logic signed [SUM_BITS-1:0] hsum_ff, hsum_in, vsum_ff, vsum_in;
   logic signed [SUM_BITS-1:0] sat_sum;
   logic signed [AW-1:0]       add_a, add_r;
   logic                       pressed;
   key_hit_type                khit;

   assign pressed = |req_data.event_value;
   assign khit    = key_lookup(req_data.event_code);

   // one saturating adder shared by both axes
   always_comb begin
      add_a = (req_data.event_code == CODE_REL_X) ? AW'(hsum_ff) : AW'(vsum_ff);
      add_r = add_a + AW'(req_data.event_value);
      if (add_r > SUM_MAX)
         sat_sum = SUM_MAX[SUM_BITS-1:0];
      else if (add_r < SUM_MIN)
         sat_sum = SUM_MIN[SUM_BITS-1:0];
      else
         sat_sum = add_r[SUM_BITS-1:0];
   end

   always_comb begin
      key_in  = key_ff;
      lbtn_in = lbtn_ff;
      rbtn_in = rbtn_ff;
      hsum_in = hsum_ff;
      vsum_in = vsum_ff;
      if (req_take) begin
         unique case (mode)
            MODE_KEY: begin
               if (khit.hit)
                  key_in[khit.bit_idx] = pressed;
               else if (req_data.event_code == CODE_MOUSE_L)
                  lbtn_in = pressed;
               else if (req_data.event_code == CODE_MOUSE_R)
                  rbtn_in = pressed;
            end
            MODE_MOTION: begin
               if (req_data.event_code == CODE_REL_X)
                  hsum_in = sat_sum;
               else if (req_data.event_code == CODE_REL_Y)
                  vsum_in = sat_sum;
            end
            MODE_TICK: begin
               hsum_in = '0;
               vsum_in = '0;
            end
            default: ;
         endcase
      end
   end

   // ---------------- tick capture ----------------
   logic signed [PW-1:0] px_ff, px_in, py_ff, py_in;
   logic [15:0]          skey_ff, skey_in;
   logic                 slb_ff, slb_in, srb_ff, srb_in;
   logic                 tick_take;

   assign tick_take = req_take && is_tick;

   always_comb begin
      px_in   = px_ff;
      py_in   = py_ff;
      skey_in = skey_ff;
      slb_in  = slb_ff;
      srb_in  = srb_ff;
      if (tick_take) begin
         px_in   = PW'(hsum_ff) * PW'(gain_ff);
         py_in   = PW'(vsum_ff) * PW'(gain_ff);
         skey_in = key_ff;
         slb_in  = lbtn_ff;
         srb_in  = rbtn_ff;
      end
   end

   // Q8.8 scale: truncate toward zero, optional negate, clamp to int16
   function automatic logic [15:0] scale_word(input logic signed [PW-1:0] p,
                                              input logic neg);
      logic signed [PW-1:0] biased;
      logic signed [NW-1:0] q;
      logic signed [NW-1:0] v;
      logic [15:0]          w;
      biased = p + (p[PW-1] ? PW'(255) : PW'(0));
      q      = NW'(signed'(biased[PW-1:8]));
      v      = neg ? -q : q;
      if (v > MOUSE_MAX)
         w = MOUSE_MAX[15:0];
      else if (v < MOUSE_MIN)
         w = MOUSE_MIN[15:0];
      else
         w = v[15:0];
      return w;
   endfunction

   // products hold for the whole frame; words are ready well before byte 6
   logic [15:0] mx_ff, mx_in, my_ff, my_in;
   assign mx_in = scale_word(px_ff, 1'b0);
   assign my_in = scale_word(py_ff, inv_ff);

   // ---------------- frame streamer ----------------
   logic [7:0] byte_sel;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      case (idx_ff)
         5'd0:      byte_sel = CH_CENTER[7:0];
         5'd1:      byte_sel = {CH_CENTER[4:0], CH_CENTER[10:8]};
         5'd2:      byte_sel = {CH_CENTER[1:0], CH_CENTER[10:5]};
         5'd3:      byte_sel = CH_CENTER[9:2];
         5'd4:      byte_sel = {CH_CENTER[6:0], CH_CENTER[10]};
         B_SWITCH:  byte_sel = {lsw_ff, rsw_ff, CH_CENTER[10:7]};
         B_MX_LO:   byte_sel = mx_ff[7:0];
         B_MX_HI:   byte_sel = mx_ff[15:8];
         B_MY_LO:   byte_sel = my_ff[7:0];
         B_MY_HI:   byte_sel = my_ff[15:8];
         B_LBTN:    byte_sel = {7'd0, slb_ff};
         B_RBTN:    byte_sel = {7'd0, srb_ff};
         B_KEY_LO:  byte_sel = skey_ff[7:0];
         B_KEY_HI:  byte_sel = skey_ff[15:8];
         5'd16:     byte_sel = CH_CENTER[7:0];
         LAST_IDX:  byte_sel = {5'd0, CH_CENTER[10:8]};
         default:   byte_sel = 8'd0;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load)
         rsp_valid_in = 1'b0;
      if (send) begin
         rsp_valid_in     = 1'b1;
         rsp_in.frame_byte = byte_sel;
         rsp_in.last_byte  = (idx_ff == LAST_IDX);
         idx_in            = idx_ff + IDX_W'(1);
         if (idx_ff == LAST_IDX)
            busy_in = 1'b0;
      end
      if (tick_take) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= 16'sd256;
         inv_ff       <= 1'b0;
         lsw_ff       <= 2'd1;
         rsw_ff       <= 2'd3;
         key_ff       <= '0;
         lbtn_ff      <= 1'b0;
         rbtn_ff      <= 1'b0;
         hsum_ff      <= '0;
         vsum_ff      <= '0;
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         inv_ff       <= inv_in;
         lsw_ff       <= lsw_in;
         rsw_ff       <= rsw_in;
         key_ff       <= key_in;
         lbtn_ff      <= lbtn_in;
         rbtn_ff      <= rbtn_in;
         hsum_ff      <= hsum_in;
         vsum_ff      <= vsum_in;
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      py_ff   <= py_in;
      skey_ff <= skey_in;
      slb_ff  <= slb_in;
      srb_ff  <= srb_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      rsp_ff  <= rsp_in;
   end

   // ---------------- assertions ----------------
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= LAST_IDX)
      else $error("frame index past last byte");

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      tick_take |=> busy_ff && idx_ff == '0)
      else $error("tick did not start a frame");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      send_last && !tick_take |=> !busy_ff)
      else $error("frame kept running after last byte");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      send |=> rsp_valid_ff && (rsp_ff.last_byte == ($past(idx_ff) == LAST_IDX)))
      else $error("last byte flag out of step with index");

endmodule
